// ===== hdl/tfst_pkg.sv =====
// ----------------------------------------------------------------------------
// tfst_pkg
// Types, constants and the tcp state transition function of the flow tracker.
// ----------------------------------------------------------------------------
package tfst_pkg;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  F_FIN     = 8'h01;
  localparam logic [7:0]  F_SYN     = 8'h02;
  localparam logic [7:0]  F_RST     = 8'h04;
  localparam logic [7:0]  F_ACK     = 8'h10;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    ST_NEW          = 4'd0,
    ST_SYN_SENT     = 4'd1,
    ST_SYN_RECEIVED = 4'd2,
    ST_ESTABLISHED  = 4'd3,
    ST_FIN_WAIT_1   = 4'd4,
    ST_FIN_WAIT_2   = 4'd5,
    ST_CLOSE_WAIT   = 4'd6,
    ST_CLOSING      = 4'd7,
    ST_LAST_ACK     = 4'd8,
    ST_TIME_WAIT    = 4'd9,
    ST_CLOSED       = 4'd10
  } conn_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_STRD,
    BS_UPD,
    BS_OUT
  } back_state_t;

  typedef struct packed {
    logic [15:0] dp;
    logic [15:0] sp;
    logic [31:0] da;
    logic [31:0] sa;
  } flow_key_t;

  typedef struct packed {
    logic [7:0] flags;
    flow_key_t  key;
  } pkt_t;

  typedef struct packed {
    logic [5:0] flow_index;
    logic       table_full;
    logic       new_flow;
    logic       from_originator;
    logic       state_changed;
    logic [3:0] post_state;
    logic [3:0] old_state;
  } result_t;

  function automatic conn_state_t next_state(conn_state_t s, logic [7:0] flags);
    logic syn;
    logic ack;
    logic fin;
    conn_state_t n;
    syn = |(flags & F_SYN);
    ack = |(flags & F_ACK);
    fin = |(flags & F_FIN);
    n   = s;
    if (|(flags & F_RST)) begin
      n = ST_CLOSED;
    end else begin
      unique case (s)
        ST_NEW: begin
          if (syn && !ack)     n = ST_SYN_SENT;
          else if (syn && ack) n = ST_SYN_RECEIVED;
          else if (ack)        n = ST_ESTABLISHED;
        end
        ST_SYN_SENT: begin
          if (syn && ack) n = ST_SYN_RECEIVED;
          else if (ack)   n = ST_ESTABLISHED;
        end
        ST_SYN_RECEIVED: if (ack) n = ST_ESTABLISHED;
        ST_ESTABLISHED:  if (fin) n = ST_FIN_WAIT_1;
        ST_FIN_WAIT_1: begin
          if (fin)      n = ST_CLOSING;
          else if (ack) n = ST_FIN_WAIT_2;
        end
        ST_FIN_WAIT_2:   if (fin) n = ST_TIME_WAIT;
        ST_CLOSING:      if (ack) n = ST_TIME_WAIT;
        ST_CLOSE_WAIT:   if (fin) n = ST_LAST_ACK;
        ST_LAST_ACK:     if (ack) n = ST_CLOSED;
        default:         n = s;
      endcase
    end
    return n;
  endfunction

endpackage

// ===== hdl/tfst_front.sv =====
// ----------------------------------------------------------------------------
// tfst_front
// Accepts headers, drops everything that is not ipv4 tcp, queues the rest.
// ----------------------------------------------------------------------------
module tfst_front import tfst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_valid,
  input  logic                 q_pop,
  output pkt_t                 q_pkt
);

  pkt_t        mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        is_tcp;
  logic        push;
  logic        pop;
  pkt_t        pkt;

  assign pkt.key.sa = in_tdata[55:24];
  assign pkt.key.da = in_tdata[87:56];
  assign pkt.key.sp = in_tdata[103:88];
  assign pkt.key.dp = in_tdata[119:104];
  assign pkt.flags  = in_tdata[127:120];
  assign is_tcp     = (in_tdata[15:0] == ETH_IPV4) && (in_tdata[23:16] == PROTO_TCP);

  assign in_tready = (cnt_r != 2'd2);
  // non-tcp transactions are taken and dropped here
  assign push      = in_tvalid && in_tready && is_tcp;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_pkt     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= pkt;
    end
  end

endmodule

// ===== hdl/tfst_back.sv =====
// ----------------------------------------------------------------------------
// tfst_back
// Flow table: scans keys one entry a cycle, allocates, updates tcp state.
// ----------------------------------------------------------------------------
module tfst_back import tfst_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  pkt_t                  q_pkt,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  flow_key_t   key_mem [TABLE_DEPTH];
  conn_state_t st_mem  [TABLE_DEPTH];

  back_state_t state_r, state_nxt;
  pkt_t        pkt_r, pkt_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic        fwd_r, fwd_nxt;
  result_t     res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  flow_key_t   key_q;
  conn_state_t st_q;
  logic        issue;
  logic        m_fwd;
  logic        m_rev;
  logic        key_we;
  logic        st_we;
  logic [IW-1:0] wr_idx;
  conn_state_t st_wdata;
  conn_state_t new_st;
  conn_state_t alloc_st;

  assign issue = (state_r == BS_SCAN) && (scan_r < used_r);
  assign m_fwd = (key_q.sa == pkt_r.key.sa) && (key_q.sp == pkt_r.key.sp) &&
                 (key_q.da == pkt_r.key.da) && (key_q.dp == pkt_r.key.dp);
  assign m_rev = (key_q.sa == pkt_r.key.da) && (key_q.sp == pkt_r.key.dp) &&
                 (key_q.da == pkt_r.key.sa) && (key_q.dp == pkt_r.key.sp);
  assign new_st   = next_state(st_q, pkt_r.flags);
  assign alloc_st = next_state(ST_NEW, pkt_r.flags);

  always_comb begin
    state_nxt     = state_r;
    pkt_nxt       = pkt_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = scan_r[IW-1:0];
    hit_idx_nxt   = hit_idx_r;
    fwd_nxt       = fwd_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    key_we        = 1'b0;
    st_we         = 1'b0;
    wr_idx        = hit_idx_r;
    st_wdata      = new_st;
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          pkt_nxt   = q_pkt;
          scan_nxt  = '0;
          state_nxt = BS_SCAN;
        end
      end
      BS_SCAN: begin
        cmp_vld_nxt = issue;
        if (issue) scan_nxt = scan_r + CW'(1);
        if (cmp_vld_r && (m_fwd || m_rev)) begin
          // lowest index wins, forward before reverse
          hit_idx_nxt = cmp_idx_r;
          fwd_nxt     = m_fwd;
          cmp_vld_nxt = 1'b0;
          state_nxt   = BS_STRD;
        end else if (!issue && !cmp_vld_r) begin
          if (used_r == CW'(TABLE_DEPTH)) begin
            res_nxt            = '0;
            res_nxt.table_full = 1'b1;
          end else begin
            wr_idx                  = used_r[IW-1:0];
            key_we                  = 1'b1;
            st_we                   = 1'b1;
            st_wdata                = alloc_st;
            used_nxt                = used_r + CW'(1);
            res_nxt.old_state       = ST_NEW;
            res_nxt.post_state      = alloc_st;
            res_nxt.state_changed   = (alloc_st != ST_NEW);
            res_nxt.from_originator = 1'b1;
            res_nxt.new_flow        = 1'b1;
            res_nxt.table_full      = 1'b0;
            res_nxt.flow_index      = 6'(used_r[IW-1:0]);
          end
          state_nxt = BS_OUT;
        end
      end
      BS_STRD: state_nxt = BS_UPD;
      BS_UPD: begin
        st_we                   = 1'b1;
        res_nxt.old_state       = st_q;
        res_nxt.post_state      = new_st;
        res_nxt.state_changed   = (new_st != st_q);
        res_nxt.from_originator = fwd_r;
        res_nxt.new_flow        = 1'b0;
        res_nxt.table_full      = 1'b0;
        res_nxt.flow_index      = 6'(hit_idx_r);
        state_nxt               = BS_OUT;
      end
      BS_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r     <= pkt_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    fwd_r     <= fwd_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_idx] <= pkt_r.key;
    key_q <= key_mem[scan_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[wr_idx] <= st_wdata;
    st_q <= st_mem[hit_idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_r};

endmodule

// ===== hdl/tcp_flow_state_tracker.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker
// TCP connection tracker: flow lookup in both directions, allocation, state.
// ----------------------------------------------------------------------------
// One ipv4 tcp header in gives one result out; other headers are taken and
// dropped. A two-entry queue sits between the classifier and the flow table,
// and a result register parts the table from the output. The table keeps its
// keys in a single-port-read memory that is scanned one entry per cycle over
// the allocated entries only. The table takes one item at a time: it pops the
// queue, scans, reads and updates the state on a hit or allocates on a miss
// when there is room, and hands the result to the output register; a result
// that waits on the output holds the table. Entries fill in order and are
// never freed, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker import tfst_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // eth_type, ip_protocol, src_addr, dst_addr, src_port, dst_port, tcp_flags
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // old_state, post_state, state_changed, from_originator, new_flow,
  // table_full, flow_index, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic q_valid;
  logic q_pop;
  pkt_t q_pkt;

  tfst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_pkt    (q_pkt)
  );

  tfst_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_pkt     (q_pkt),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tcp flow state tracker. Drives parsed headers
// (directed handshakes, random flow traffic, back-pressure, table fill) and
// checks every result against an in-bench flow table model.
// ----------------------------------------------------------------------------
module testbench;
  import tfst_pkg::*;

  localparam int DEPTH     = 64;
  localparam int POOL_SIZE = 40;
  localparam int WD_LIMIT  = 20000;

  // header fields, lowest bits last
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] dp;
    logic [15:0] sp;
    logic [31:0] da;
    logic [31:0] sa;
    logic [7:0]  proto;
    logic [15:0] et;
  } hdr_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // flow table model
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_orig_addr [DEPTH];
  logic [31:0] tbl_resp_addr [DEPTH];
  logic [15:0] tbl_orig_port [DEPTH];
  logic [15:0] tbl_resp_port [DEPTH];
  conn_state_t tbl_state [DEPTH];
  int          flows_alloc;

  result_t pending_results[$];
  int      err_cnt;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;
  int      quiet_cycles = 0;

  // random flow pool
  logic [31:0] pool_sa [POOL_SIZE];
  logic [31:0] pool_da [POOL_SIZE];
  logic [15:0] pool_sp [POOL_SIZE];
  logic [15:0] pool_dp [POOL_SIZE];
  int          pool_step [POOL_SIZE];

  tcp_flow_state_tracker #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic conn_state_t flow_next_state(conn_state_t cur, logic [7:0] flags);
    logic syn;
    logic ack;
    logic fin;
    syn = flags[1];
    ack = flags[4];
    fin = flags[0];
    if (flags[2]) return ST_CLOSED;
    case (cur)
      ST_NEW: begin
        if (syn) return ack ? ST_SYN_RECEIVED : ST_SYN_SENT;
        if (ack) return ST_ESTABLISHED;
      end
      ST_SYN_SENT: begin
        if (syn && ack) return ST_SYN_RECEIVED;
        if (ack) return ST_ESTABLISHED;
      end
      ST_SYN_RECEIVED: if (ack) return ST_ESTABLISHED;
      ST_ESTABLISHED:  if (fin) return ST_FIN_WAIT_1;
      ST_FIN_WAIT_1: begin
        // fin wins over ack here
        if (fin) return ST_CLOSING;
        if (ack) return ST_FIN_WAIT_2;
      end
      ST_FIN_WAIT_2:   if (fin) return ST_TIME_WAIT;
      ST_CLOSING:      if (ack) return ST_TIME_WAIT;
      ST_CLOSE_WAIT:   if (fin) return ST_LAST_ACK;
      ST_LAST_ACK:     if (ack) return ST_CLOSED;
      default: ;
    endcase
    return cur;
  endfunction

  task automatic track_header(input hdr_t h);
    int          hit;
    logic        fwd;
    logic        fresh;
    conn_state_t prev;
    conn_state_t nxt;
    result_t     r;
    hit   = -1;
    fwd   = 1'b0;
    fresh = 1'b0;
    r     = '0;
    if (h.et != ETH_IPV4 || h.proto != PROTO_TCP) return;
    for (int i = 0; i < DEPTH && hit < 0; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_orig_addr[i] == h.sa && tbl_orig_port[i] == h.sp &&
            tbl_resp_addr[i] == h.da && tbl_resp_port[i] == h.dp) begin
          hit = i;
          fwd = 1'b1;
        end else if (tbl_orig_addr[i] == h.da && tbl_orig_port[i] == h.dp &&
                     tbl_resp_addr[i] == h.sa && tbl_resp_port[i] == h.sp) begin
          hit = i;
        end
      end
    end
    if (hit < 0) begin
      for (int i = 0; i < DEPTH && hit < 0; i++) begin
        if (!tbl_valid[i]) hit = i;
      end
      if (hit < 0) begin
        r.table_full = 1'b1;
        pending_results.push_back(r);
        return;
      end
      tbl_valid[hit]     = 1'b1;
      tbl_orig_addr[hit] = h.sa;
      tbl_orig_port[hit] = h.sp;
      tbl_resp_addr[hit] = h.da;
      tbl_resp_port[hit] = h.dp;
      tbl_state[hit]     = ST_NEW;
      flows_alloc++;
      fresh = 1'b1;
      fwd   = 1'b1;
    end
    prev = tbl_state[hit];
    nxt  = flow_next_state(prev, h.flags);
    tbl_state[hit]    = nxt;
    r.old_state       = prev;
    r.post_state      = nxt;
    r.state_changed   = (prev != nxt);
    r.from_originator = fwd;
    r.new_flow        = fresh;
    r.flow_index      = hit[5:0];
    pending_results.push_back(r);
  endtask

  // one transaction on the input side; valid stays high between back-to-back items
  task automatic send_header(input hdr_t h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = h;
    do @(posedge clk); while (!in_tready);
    track_header(h);
  endtask

  task automatic send_tcp(input logic [31:0] sa, input logic [31:0] da,
                          input logic [15:0] sp, input logic [15:0] dp,
                          input logic [7:0] flags);
    hdr_t h;
    h.et = ETH_IPV4; h.proto = PROTO_TCP;
    h.sa = sa; h.da = da; h.sp = sp; h.dp = dp; h.flags = flags;
    send_header(h);
  endtask

  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.old_state != want.old_state) begin
          $error("old_state exp %0d got %0d", want.old_state, got.old_state); err_cnt++;
        end
        if (got.post_state != want.post_state) begin
          $error("post_state exp %0d got %0d", want.post_state, got.post_state); err_cnt++;
        end
        if (got.state_changed != want.state_changed) begin
          $error("state_changed exp %0d got %0d", want.state_changed, got.state_changed);
          err_cnt++;
        end
        if (got.from_originator != want.from_originator) begin
          $error("from_originator exp %0d got %0d", want.from_originator,
                 got.from_originator);
          err_cnt++;
        end
        if (got.new_flow != want.new_flow) begin
          $error("new_flow exp %0d got %0d", want.new_flow, got.new_flow); err_cnt++;
        end
        if (got.table_full != want.table_full) begin
          $error("table_full exp %0d got %0d", want.table_full, got.table_full); err_cnt++;
        end
        if (got.flow_index != want.flow_index) begin
          $error("flow_index exp %0d got %0d", want.flow_index, got.flow_index); err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    hdr_t h;
    // ignored headers: other ether type, other protocol
    h = {8'hff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, PROTO_TCP, 16'hffff};
    send_header(h);
    h = {8'hff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 8'hff, ETH_IPV4};
    send_header(h);
    // full handshake, simultaneous close, terminal states
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_SYN);
    send_tcp(32'h0a000002, 32'h0a000001, 16'd80, 16'd1234, F_SYN | F_ACK);
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_ACK);
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_FIN);
    send_tcp(32'h0a000002, 32'h0a000001, 16'd80, 16'd1234, F_FIN | F_ACK);
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_ACK);
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_FIN);
    send_tcp(32'h0a000002, 32'h0a000001, 16'd80, 16'd1234, F_RST);
    send_tcp(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, F_SYN);
    // ack opens directly, then reset from established
    send_tcp(32'hc0a80001, 32'hc0a80002, 16'd5000, 16'd22, F_ACK);
    send_tcp(32'hc0a80002, 32'hc0a80001, 16'd22, 16'd5000, F_RST | F_ACK);
    // syn+ack on a new flow, no flags, ack
    send_tcp(32'h01020304, 32'h05060708, 16'd40000, 16'd443, F_SYN | F_ACK);
    send_tcp(32'h05060708, 32'h01020304, 16'd443, 16'd40000, 8'h00);
    send_tcp(32'h05060708, 32'h01020304, 16'd443, 16'd40000, F_ACK);
    // source equals destination: originator direction wins
    send_tcp(32'h7f000001, 32'h7f000001, 16'd7, 16'd7, F_SYN);
    send_tcp(32'h7f000001, 32'h7f000001, 16'd7, 16'd7, F_ACK);
    // extreme tuple with all flag bits set
    send_tcp(32'hffffffff, 32'h00000000, 16'hffff, 16'h0000, 8'hff);
    // orderly close through fin_wait_2 and time_wait
    send_tcp(32'h0b000001, 32'h0b000002, 16'd1, 16'd2, F_SYN);
    send_tcp(32'h0b000002, 32'h0b000001, 16'd2, 16'd1, F_ACK);
    send_tcp(32'h0b000001, 32'h0b000002, 16'd1, 16'd2, F_FIN | 8'he8);
    send_tcp(32'h0b000002, 32'h0b000001, 16'd2, 16'd1, F_ACK);
    send_tcp(32'h0b000002, 32'h0b000001, 16'd2, 16'd1, F_FIN);
    send_tcp(32'h0b000001, 32'h0b000002, 16'd1, 16'd2, F_RST);
  endtask

  task automatic send_pool_item();
    int          k;
    int          r;
    logic [7:0]  fl;
    logic        rev;
    hdr_t        h;
    k   = $urandom_range(POOL_SIZE - 1);
    r   = $urandom_range(99);
    rev = 1'($urandom_range(1));
    fl  = 8'($urandom);
    if (r < 10) begin
      // noise that the block drops
      h = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(1)) h.et = ETH_IPV4;
      else h.proto = PROTO_TCP;
      if (h.et == ETH_IPV4 && h.proto == PROTO_TCP) h.proto = 8'd17;
      send_header(h);
      return;
    end
    if (r >= 30) begin
      // scripted connection life with random spare flag bits
      fl &= 8'he8;
      case (pool_step[k] % 8)
        0: begin fl |= F_SYN;         rev = 1'b0; end
        1: begin fl |= F_SYN | F_ACK; rev = 1'b1; end
        2: begin fl |= F_ACK;         rev = 1'b0; end
        3: begin fl |= F_ACK;         rev = 1'b1; end
        4: begin fl |= F_FIN;         rev = 1'b0; end
        5: begin fl |= F_ACK;         rev = 1'b1; end
        6: begin fl |= F_FIN;         rev = 1'b1; end
        default: begin fl |= F_RST;   rev = 1'b0; end
      endcase
      pool_step[k]++;
    end
    if (rev) send_tcp(pool_da[k], pool_sa[k], pool_dp[k], pool_sp[k], fl);
    else     send_tcp(pool_sa[k], pool_da[k], pool_sp[k], pool_dp[k], fl);
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) send_pool_item();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_pool_item();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 80; i++) begin
      if ($urandom_range(3) == 0) send_pool_item();
      else send_tcp($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < WD_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    err_cnt       = 0;
    flows_alloc   = 0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_sa[i]   = $urandom;
      pool_da[i]   = $urandom;
      pool_sp[i]   = 16'($urandom);
      pool_dp[i]   = 16'($urandom);
      pool_step[i] = $urandom_range(7);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 71;
    test_directed();
    test_random_traffic(350);
    send_idle_pct = 71;
    recv_idle_pct = 33;
    test_random_traffic(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);
    test_backpressure();
    test_table_full();
    @(negedge clk);
    in_tvalid = 1'b0;
    drain();

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
